[src/blc_pkg.sv]
// ---------------------------------------------------------------------------
// blc_pkg
// Shared types and constants for the battery level classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

    // Configuration write port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRIT_THR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EMERG_THR = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYST      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PMIN      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PMAX      = 3'd5;

    // Register reset values and fixed widths
    localparam int HYST_BITS     = 10;
    localparam int RST_THR_BITS  = 13;
    localparam logic [RST_THR_BITS-1:0] RST_LOW_THR   = 13'd3600;
    localparam logic [RST_THR_BITS-1:0] RST_CRIT_THR  = 13'd3300;
    localparam logic [RST_THR_BITS-1:0] RST_EMERG_THR = 13'd3000;
    localparam logic [HYST_BITS-1:0]    RST_HYST      = 10'd100;
    localparam logic [RST_THR_BITS-1:0] RST_PMIN      = 13'd2500;
    localparam logic [RST_THR_BITS-1:0] RST_PMAX      = 13'd6000;

    // Energy levels, ordered from best to worst
    typedef enum logic [1:0] {
        LVL_NOMINAL   = 2'd0,
        LVL_LOW       = 2'd1,
        LVL_CRITICAL  = 2'd2,
        LVL_EMERGENCY = 2'd3
    } t_level;

    // One classification result
    typedef struct packed {
        t_level energy_level;
        logic   level_changed;
        logic   report_low;
        logic   report_critical;
        logic   report_emergency;
        logic   clear_low;
        logic   clear_critical;
        logic   clear_emergency;
        logic   read_error;
        logic   implausible;
    } t_result;

endpackage

`default_nettype wire

[src/blc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// blc_cfg_regs
// Threshold, hysteresis and plausibility window registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blc_cfg_regs
    import blc_pkg::*;
#(
    parameter int VOLT_BITS = 13,
    parameter int REG_BITS  = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_wr_data,
    output logic [REG_BITS-1:0]           o_low_thr,
    output logic [REG_BITS-1:0]           o_crit_thr,
    output logic [REG_BITS-1:0]           o_emerg_thr,
    output logic [HYST_BITS-1:0]          o_hyst,
    output logic [REG_BITS-1:0]           o_pmin,
    output logic [REG_BITS-1:0]           o_pmax
);

    logic [REG_BITS-1:0] w_volt_data;

    // threshold and window writes keep only the voltage bits, zero extended
    assign w_volt_data = REG_BITS'(i_wr_data[VOLT_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_low_thr   <= REG_BITS'(RST_LOW_THR);
            o_crit_thr  <= REG_BITS'(RST_CRIT_THR);
            o_emerg_thr <= REG_BITS'(RST_EMERG_THR);
            o_hyst      <= RST_HYST;
            o_pmin      <= REG_BITS'(RST_PMIN);
            o_pmax      <= REG_BITS'(RST_PMAX);
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_LOW_THR:   o_low_thr   <= w_volt_data;
                CFG_CRIT_THR:  o_crit_thr  <= w_volt_data;
                CFG_EMERG_THR: o_emerg_thr <= w_volt_data;
                CFG_HYST:      o_hyst      <= i_wr_data[HYST_BITS-1:0];
                CFG_PMIN:      o_pmin      <= w_volt_data;
                CFG_PMAX:      o_pmax      <= w_volt_data;
                default:       ;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/blc_classify.sv]
// ---------------------------------------------------------------------------
// blc_classify
// Level classification with hysteresis and fault action decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blc_classify
    import blc_pkg::*;
#(
    parameter int VOLT_BITS = 13,
    parameter int REG_BITS  = 13
) (
    input  wire logic                 i_read_ok,
    input  wire logic [VOLT_BITS-1:0] i_vbatt_mv,
    input  wire t_level               i_prev_level,
    input  wire logic [REG_BITS-1:0]  i_low_thr,
    input  wire logic [REG_BITS-1:0]  i_crit_thr,
    input  wire logic [REG_BITS-1:0]  i_emerg_thr,
    input  wire logic [HYST_BITS-1:0] i_hyst,
    input  wire logic [REG_BITS-1:0]  i_pmin,
    input  wire logic [REG_BITS-1:0]  i_pmax,
    output t_result                   o_result
);

    localparam int SUM_BITS = REG_BITS + 1;

    // v - off < thr is tested as v < thr + off, so no signed math is needed
    function automatic t_level classify(
        input logic [SUM_BITS-1:0] v,
        input logic [SUM_BITS-1:0] off,
        input logic [REG_BITS-1:0] emerg,
        input logic [REG_BITS-1:0] crit,
        input logic [REG_BITS-1:0] low
    );
        t_level lvl;
        if (v < SUM_BITS'(emerg) + off)     lvl = LVL_EMERGENCY;
        else if (v < SUM_BITS'(crit) + off) lvl = LVL_CRITICAL;
        else if (v < SUM_BITS'(low) + off)  lvl = LVL_LOW;
        else                                lvl = LVL_NOMINAL;
        return lvl;
    endfunction

    logic [SUM_BITS-1:0] w_v;
    logic [SUM_BITS-1:0] w_hyst;
    logic                w_out_window;
    t_level              w_raw;
    t_level              w_recover;
    t_level              w_next;

    assign w_v          = SUM_BITS'(i_vbatt_mv);
    assign w_hyst       = SUM_BITS'(i_hyst);
    assign w_out_window = (w_v < SUM_BITS'(i_pmin)) || (w_v > SUM_BITS'(i_pmax));
    assign w_raw        = classify(w_v, '0, i_emerg_thr, i_crit_thr, i_low_thr);
    assign w_recover    = classify(w_v, w_hyst, i_emerg_thr, i_crit_thr, i_low_thr);

    // out of window forces nominal; worse or equal is taken at once, improvement is judged with hysteresis
    always_comb begin
        if (w_out_window)               w_next = LVL_NOMINAL;
        else if (w_raw >= i_prev_level) w_next = w_raw;
        else                            w_next = w_recover;
    end

    // read error holds the level; fault actions on a level change
    always_comb begin
        o_result = '0;
        if (!i_read_ok) begin
            o_result.energy_level = i_prev_level;
            o_result.read_error   = 1'b1;
        end else begin
            o_result.energy_level = w_next;
            o_result.implausible  = w_out_window;
            if (w_next != i_prev_level) begin
                o_result.level_changed = 1'b1;
                case (w_next)
                    LVL_NOMINAL: begin
                        o_result.clear_low       = 1'b1;
                        o_result.clear_critical  = 1'b1;
                        o_result.clear_emergency = 1'b1;
                    end
                    LVL_LOW: begin
                        o_result.report_low = 1'b1;
                        if (i_prev_level > LVL_LOW) begin
                            o_result.clear_critical  = 1'b1;
                            o_result.clear_emergency = 1'b1;
                        end
                    end
                    LVL_CRITICAL: begin
                        o_result.clear_low       = 1'b1;
                        o_result.report_critical = 1'b1;
                    end
                    default: begin
                        o_result.clear_low        = 1'b1;
                        o_result.report_emergency = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[src/battery_level_classifier.sv]
// Battery level classifier.
// Path: an accepted input transaction goes through the input register, then the classify logic
// into the result register, which drives the outputs.
// Throughput: one transaction per cycle unless the output stalls; the level feedback closes within the result stage.
// Reset: synchronous active low; level returns to nominal, registers to defaults.
// ---------------------------------------------------------------------------
// battery_level_classifier
// Top level: input stage, classifier, result stage and configuration registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_level_classifier
    import blc_pkg::*;
#(
    parameter int VOLT_BITS = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_read_ok,
    input  wire logic [VOLT_BITS-1:0]     i_vbatt_mv,
    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_energy_level,
    output logic                          o_level_changed,
    output logic                          o_report_low,
    output logic                          o_report_critical,
    output logic                          o_report_emergency,
    output logic                          o_clear_low,
    output logic                          o_clear_critical,
    output logic                          o_clear_emergency,
    output logic                          o_read_error,
    output logic                          o_implausible,
    // configuration channel
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int REG_BITS = (VOLT_BITS > RST_THR_BITS) ? VOLT_BITS : RST_THR_BITS;

    logic [REG_BITS-1:0]  w_low_thr;
    logic [REG_BITS-1:0]  w_crit_thr;
    logic [REG_BITS-1:0]  w_emerg_thr;
    logic [HYST_BITS-1:0] w_hyst;
    logic [REG_BITS-1:0]  w_pmin;
    logic [REG_BITS-1:0]  w_pmax;

    logic                 r_in_valid;
    logic                 r_read_ok;
    logic [VOLT_BITS-1:0] r_vbatt_mv;
    logic                 r_out_valid;
    t_result              r_out_result;
    t_level               r_prev_level;
    t_result              w_result;
    logic                 w_out_load;
    logic                 w_advance;

    assign o_cfg_ready = 1'b1;

    blc_cfg_regs #(
        .VOLT_BITS (VOLT_BITS),
        .REG_BITS  (REG_BITS)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg_valid & o_cfg_ready),
        .i_wr_index  (i_cfg_index),
        .i_wr_data   (i_cfg_data),
        .o_low_thr   (w_low_thr),
        .o_crit_thr  (w_crit_thr),
        .o_emerg_thr (w_emerg_thr),
        .o_hyst      (w_hyst),
        .o_pmin      (w_pmin),
        .o_pmax      (w_pmax)
    );

    // handshake: result stage frees up when empty or being taken
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_load;
    assign o_in_stall = r_in_valid && !w_out_load;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_read_ok  <= i_read_ok;
            r_vbatt_mv <= i_vbatt_mv;
        end
    end

    blc_classify #(
        .VOLT_BITS (VOLT_BITS),
        .REG_BITS  (REG_BITS)
    ) u_classify (
        .i_read_ok    (r_read_ok),
        .i_vbatt_mv   (r_vbatt_mv),
        .i_prev_level (r_prev_level),
        .i_low_thr    (w_low_thr),
        .i_crit_thr   (w_crit_thr),
        .i_emerg_thr  (w_emerg_thr),
        .i_hyst       (w_hyst),
        .i_pmin       (w_pmin),
        .i_pmax       (w_pmax),
        .o_result     (w_result)
    );

    // result stage and level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_prev_level <= LVL_NOMINAL;
        end else begin
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_prev_level <= w_result.energy_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_result <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_energy_level     = r_out_result.energy_level;
    assign o_level_changed    = r_out_result.level_changed;
    assign o_report_low       = r_out_result.report_low;
    assign o_report_critical  = r_out_result.report_critical;
    assign o_report_emergency = r_out_result.report_emergency;
    assign o_clear_low        = r_out_result.clear_low;
    assign o_clear_critical   = r_out_result.clear_critical;
    assign o_clear_emergency  = r_out_result.clear_emergency;
    assign o_read_error       = r_out_result.read_error;
    assign o_implausible      = r_out_result.implausible;

endmodule

`default_nettype wire
